FILE: rtl/core/yoag_pkg.sv
package yoag_pkg;

    // fixed field widths
    localparam int unsigned DIM_W   = 13;   // bg/ov width and height registers
    localparam int unsigned OFF_W   = 12;   // offset registers
    localparam int unsigned CFG_W   = 13;   // config write data
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned PIXEL_W = 8;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OV_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OV_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_X     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_Y     = 3'd5;

    // config reset values
    localparam logic [DIM_W-1:0] BG_WIDTH_RST  = 13'd1920;
    localparam logic [DIM_W-1:0] BG_HEIGHT_RST = 13'd1080;
    localparam logic [DIM_W-1:0] OV_WIDTH_RST  = 13'd1288;
    localparam logic [DIM_W-1:0] OV_HEIGHT_RST = 13'd592;

    // I420 plane in file order
    typedef enum logic [1:0] {
        PLANE_Y = 2'd0,
        PLANE_U = 2'd1,
        PLANE_V = 2'd2
    } plane_t;

endpackage

FILE: rtl/core/yuv420_overlay_address_gen_core.sv
// A request passes two registers, the scan register and the result register, before its result is valid.
// Throughput: one request per clock, sustained while out_stall is low; the scan counters advance
// combinationally and the address multiply sits alone between the scan and result registers.
// Reset (rst_n, async, active low): config returns to 1920x1080 background, 1288x592
// overlay at offset (0,0); scan restarts at the first luma byte; pipeline is emptied.
module yuv420_overlay_address_gen_core #(
    parameter int unsigned MAX_DIM_BITS = 12,
    parameter int unsigned ADDR_BITS    = 25
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // config write port
    input  logic                              cfg_write_enable,
    input  logic [yoag_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [yoag_pkg::CFG_W-1:0]        cfg_data,

    // request side: overlay bytes in I420 file order
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [yoag_pkg::PIXEL_W-1:0]      pixel_byte,

    // result side: background buffer write
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ADDR_BITS-1:0]              dest_address,
    output logic [yoag_pkg::PIXEL_W-1:0]      dest_data,
    output logic                              write_enable,
    output logic                              frame_last
);
    import yoag_pkg::*;

    // CW: plane size compare width, able to hold 2^MAX_DIM_BITS and a 13-bit size.
    // TW: target row/column width (offset plus counter).
    localparam int unsigned CW = (MAX_DIM_BITS + 1 > DIM_W) ? MAX_DIM_BITS + 1 : DIM_W;
    localparam int unsigned TW = ((MAX_DIM_BITS > OFF_W) ? MAX_DIM_BITS : OFF_W) + 1;
    localparam logic [CW-1:0] DIM_CAP = CW'(1) << MAX_DIM_BITS;

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] bg_width_reg, bg_height_reg, ov_width_reg, ov_height_reg;
    logic [OFF_W-1:0] off_x_reg, off_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_width_reg  <= BG_WIDTH_RST;
            bg_height_reg <= BG_HEIGHT_RST;
            ov_width_reg  <= OV_WIDTH_RST;
            ov_height_reg <= OV_HEIGHT_RST;
            off_x_reg     <= '0;
            off_y_reg     <= '0;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                CFG_BG_WIDTH:  bg_width_reg  <= cfg_data;
                CFG_BG_HEIGHT: bg_height_reg <= cfg_data;
                CFG_OV_WIDTH:  ov_width_reg  <= cfg_data;
                CFG_OV_HEIGHT: ov_height_reg <= cfg_data;
                CFG_OFF_X:     off_x_reg     <= cfg_data[OFF_W-1:0];
                CFG_OFF_Y:     off_y_reg     <= cfg_data[OFF_W-1:0];
                default:       ;   // unmapped index, ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake / pipeline control
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_load;
    logic in_accept;

    // result register takes a new value whenever it is empty or being drained
    assign out_load  = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !out_load;
    assign in_accept = in_valid && !in_stall;

    assign s1_valid_next  = in_accept ? 1'b1 : (out_load ? 1'b0 : s1_valid_reg);
    assign out_valid_next = out_load ? s1_valid_reg : out_valid_reg;

    // ------------------------------------------------------------------
    // Scan state: plane, row, column of the next overlay byte
    // ------------------------------------------------------------------
    plane_t                  plane_reg, plane_next;
    logic [MAX_DIM_BITS-1:0] row_reg, row_next;
    logic [MAX_DIM_BITS-1:0] col_reg, col_next;

    logic             chroma;
    logic [DIM_W-1:0] ow_sel, oh_sel, bw, bh;
    logic [OFF_W-1:0] ox, oy;
    logic [CW-1:0]    ow_ext, oh_ext, pw, ph;
    logic [CW-1:0]    col_inc, row_inc;
    logic             col_wrap, row_wrap;
    logic [TW-1:0]    trow, tcol;
    logic             target_inside, target_last;

    always_comb
    begin
        chroma = (plane_reg != PLANE_Y);

        // chroma planes: halved sizes and offsets, truncated
        ow_sel = chroma ? (ov_width_reg  >> 1) : ov_width_reg;
        oh_sel = chroma ? (ov_height_reg >> 1) : ov_height_reg;
        bw     = chroma ? (bg_width_reg  >> 1) : bg_width_reg;
        bh     = chroma ? (bg_height_reg >> 1) : bg_height_reg;
        ox     = chroma ? (off_x_reg >> 1) : off_x_reg;
        oy     = chroma ? (off_y_reg >> 1) : off_y_reg;

        // empty plane counts as one byte, oversized plane is capped
        ow_ext = CW'(ow_sel);
        oh_ext = CW'(oh_sel);
        if (ow_ext == '0)
            pw = CW'(1);
        else if (ow_ext > DIM_CAP)
            pw = DIM_CAP;
        else
            pw = ow_ext;
        if (oh_ext == '0)
            ph = CW'(1);
        else if (oh_ext > DIM_CAP)
            ph = DIM_CAP;
        else
            ph = oh_ext;

        col_inc  = CW'(col_reg) + CW'(1);
        row_inc  = CW'(row_reg) + CW'(1);
        col_wrap = (col_inc >= pw);
        row_wrap = (row_inc >= ph);

        trow = TW'(oy) + TW'(row_reg);
        tcol = TW'(ox) + TW'(col_reg);

        // no write outside the background plane; address still given
        target_inside = (tcol < TW'(bw)) && (trow < TW'(bh));
        target_last   = (plane_reg == PLANE_V) && col_wrap && row_wrap;

        // raster advance; after the last V byte back to the first Y byte
        plane_next = plane_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        if (col_wrap)
        begin
            col_next = '0;
            if (row_wrap)
            begin
                row_next = '0;
                case (plane_reg)
                    PLANE_Y: plane_next = PLANE_U;
                    PLANE_U: plane_next = PLANE_V;
                    PLANE_V: plane_next = PLANE_Y;
                    default: plane_next = PLANE_Y;
                endcase
            end
            else
            begin
                row_next = row_inc[MAX_DIM_BITS-1:0];
            end
        end
        else
        begin
            col_next = col_inc[MAX_DIM_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= PLANE_Y;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else if (in_accept)
        begin
            plane_reg <= plane_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    // ------------------------------------------------------------------
    // Scan register: target coordinates and flags of the accepted byte
    // ------------------------------------------------------------------
    plane_t               s1_plane_reg;
    logic [TW-1:0]        s1_trow_reg, s1_tcol_reg;
    logic [PIXEL_W-1:0]   s1_data_reg;
    logic                 s1_inside_reg, s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_plane_reg  <= plane_reg;
            s1_trow_reg   <= trow;
            s1_tcol_reg   <= tcol;
            s1_data_reg   <= pixel_byte;
            s1_inside_reg <= target_inside;
            s1_last_reg   <= target_last;
        end
    end

    // ------------------------------------------------------------------
    // Address: plane base + pitch * target row + target column
    // ------------------------------------------------------------------
    logic [ADDR_BITS-1:0] s1_addr;

    yoag_addr #(
        .TW        (TW),
        .ADDR_BITS (ADDR_BITS)
    ) u_addr (
        .bg_width  (bg_width_reg),
        .bg_height (bg_height_reg),
        .plane     (s1_plane_reg),
        .trow      (s1_trow_reg),
        .tcol      (s1_tcol_reg),
        .addr      (s1_addr)
    );

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [ADDR_BITS-1:0] out_addr_reg;
    logic [PIXEL_W-1:0]   out_data_reg;
    logic                 out_we_reg, out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg)
        begin
            out_addr_reg <= s1_addr;
            out_data_reg <= s1_data_reg;
            out_we_reg   <= s1_inside_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign dest_address = out_addr_reg;
    assign dest_data    = out_data_reg;
    assign write_enable = out_we_reg;
    assign frame_last   = out_last_reg;

endmodule

FILE: rtl/core/yoag_addr.sv
// Address arithmetic for one request: plane base + pitch * target row + target column.
module yoag_addr #(
    parameter int unsigned TW        = 13,
    parameter int unsigned ADDR_BITS = 25
) (
    input  logic [yoag_pkg::DIM_W-1:0] bg_width,
    input  logic [yoag_pkg::DIM_W-1:0] bg_height,
    input  yoag_pkg::plane_t           plane,
    input  logic [TW-1:0]              trow,
    input  logic [TW-1:0]              tcol,
    output logic [ADDR_BITS-1:0]       addr
);
    import yoag_pkg::*;

    localparam int unsigned PROD_W = DIM_W + TW;
    localparam int unsigned CALC_W = ((ADDR_BITS > PROD_W) ? ADDR_BITS : PROD_W) + 2;

    logic [2*DIM_W-1:0] luma_size;
    logic [CALC_W-1:0]  base;
    logic [DIM_W-1:0]   pitch;
    logic [PROD_W-1:0]  row_offs;
    logic [CALC_W-1:0]  sum;

    // two multipliers side by side, no chaining
    assign luma_size = bg_width * bg_height;
    assign row_offs  = pitch * trow;

    always_comb
    begin
        case (plane)
            PLANE_Y:
            begin
                base  = '0;
                pitch = bg_width;
            end
            PLANE_U:
            begin
                base  = CALC_W'(luma_size);
                pitch = bg_width >> 1;
            end
            PLANE_V:
            begin
                base  = CALC_W'(luma_size) + CALC_W'(luma_size >> 2);
                pitch = bg_width >> 1;
            end
            default:
            begin
                base  = '0;
                pitch = bg_width;
            end
        endcase
    end

    assign sum  = base + CALC_W'(row_offs) + CALC_W'(tcol);
    assign addr = sum[ADDR_BITS-1:0];

endmodule

FILE: sim/yuv420_overlay_address_gen_core_tb.sv
module yuv420_overlay_address_gen_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import yoag_pkg::*;

    // Scan geometry limits of the block at its default parameters
    localparam int unsigned ADDR_W     = 25;
    localparam longint unsigned DIM_CAP = 64'd4096;     // 2^MAX_DIM_BITS

    // Run shape
    localparam int NUM_PHASES      = 11;
    localparam int REQS_PER_PHASE  = 50;
    localparam int LONG_HOLD       = 64;                // receiver hold-off, in cycles
    localparam int QUIET_LIMIT     = 4000;              // cycles with no traffic at all

    // One background buffer write, as the block reports it
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [PIXEL_W-1:0] data;
        logic               we;
        logic               last;
    } bg_write_t;

    // One line of the directed plan: either a register write or a request,
    // the latter optionally carrying a hand-written expected write
    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     val;
        logic [PIXEL_W-1:0]   pix;
        bit                   typed;
        logic [ADDR_W-1:0]    t_addr;
        logic                 t_we;
        logic                 t_last;
    } plan_row_t;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                 clk              = 1'b0;
    logic                 rst_n            = 1'b0;
    logic                 cfg_write_enable = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index        = '0;
    logic [CFG_W-1:0]     cfg_data         = '0;
    logic                 in_valid         = 1'b0;
    logic [PIXEL_W-1:0]   pixel_byte       = '0;
    logic                 out_stall        = 1'b0;

    logic                 in_stall;
    logic                 out_valid;
    logic [ADDR_W-1:0]    dest_address;
    logic [PIXEL_W-1:0]   dest_data;
    logic                 write_enable;
    logic                 frame_last;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    yuv420_overlay_address_gen_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .pixel_byte       (pixel_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .dest_address     (dest_address),
        .dest_data        (dest_data),
        .write_enable     (write_enable),
        .frame_last       (frame_last)
    );

    // ------------------------------------------------------------------
    // Scoreboard state
    // ------------------------------------------------------------------
    bg_write_t pending_writes[$];   // writes predicted, oldest first
    int        mismatches   = 0;
    int        quiet_cycles = 0;

    // Hand-written expectation for the request currently on offer
    bit        row_typed = 1'b0;
    bg_write_t row_exp   = '0;

    // Long receiver hold-off: stimulus bumps the ask, receiver serves it
    int        hold_asked  = 0;
    int        hold_served = 0;

    // Shadow of the block's registers and scan counters
    logic [DIM_W-1:0] sh_bg_w  = BG_WIDTH_RST;
    logic [DIM_W-1:0] sh_bg_h  = BG_HEIGHT_RST;
    logic [DIM_W-1:0] sh_ov_w  = OV_WIDTH_RST;
    logic [DIM_W-1:0] sh_ov_h  = OV_HEIGHT_RST;
    logic [OFF_W-1:0] sh_off_x = '0;
    logic [OFF_W-1:0] sh_off_y = '0;
    plane_t           scan_plane = PLANE_Y;
    logic [11:0]      scan_row   = '0;
    logic [11:0]      scan_col   = '0;

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic void shadow_reg(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] v);
        case (idx)
            CFG_BG_WIDTH:  sh_bg_w  = v;
            CFG_BG_HEIGHT: sh_bg_h  = v;
            CFG_OV_WIDTH:  sh_ov_w  = v;
            CFG_OV_HEIGHT: sh_ov_h  = v;
            CFG_OFF_X:     sh_off_x = v[OFF_W-1:0];
            CFG_OFF_Y:     sh_off_y = v[OFF_W-1:0];
            default: ;
        endcase
    endfunction

    // plane size of 0 counts as 1, anything above the cap is held at the cap
    function automatic longint unsigned plane_dim(input longint unsigned d);
        if (d == 0)
            return 1;
        if (d > DIM_CAP)
            return DIM_CAP;
        return d;
    endfunction

    // Where does this overlay byte land in the background buffer?
    // Advances the scan counters as a side effect.
    function automatic bg_write_t place_byte(input logic [PIXEL_W-1:0] p);
        longint unsigned luma, pw, ph, bw, bh, ox, oy, base, trow, tcol, row_addr, c, r;
        bg_write_t w;
        bw   = sh_bg_w;
        bh   = sh_bg_h;
        luma = bw * bh;
        c    = scan_col;
        r    = scan_row;
        if (scan_plane != PLANE_Y)
        begin
            pw   = plane_dim(sh_ov_w / 2);
            ph   = plane_dim(sh_ov_h / 2);
            bw   = bw / 2;
            bh   = bh / 2;
            ox   = sh_off_x / 2;
            oy   = sh_off_y / 2;
            base = (scan_plane == PLANE_U) ? luma : luma + luma / 4;
        end
        else
        begin
            pw   = plane_dim(sh_ov_w);
            ph   = plane_dim(sh_ov_h);
            ox   = sh_off_x;
            oy   = sh_off_y;
            base = 0;
        end
        trow     = oy + r;
        tcol     = ox + c;
        row_addr = base + bw * trow + ox;
        w.addr   = ADDR_W'(ADDR_W'(row_addr) + c);
        w.data   = p;
        w.we     = (tcol < bw) && (trow < bh);
        w.last   = (scan_plane == PLANE_V) && (c + 1 >= pw) && (r + 1 >= ph);

        // counters compare with >=, so a shrunk plane wraps on the next byte
        if (c + 1 >= pw)
        begin
            scan_col = '0;
            if (r + 1 >= ph)
            begin
                scan_row   = '0;
                scan_plane = (scan_plane == PLANE_V) ? PLANE_Y : plane_t'(scan_plane + 1);
            end
            else
                scan_row = 12'(r + 1);
        end
        else
            scan_col = 12'(c + 1);
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Bus watcher: register shadowing, prediction on request accept,
    // comparison on result accept. All sampled at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : bus_watch
        bg_write_t want;
        bit        busy;
        if (rst_n)
        begin
            busy = 1'b0;
            if (cfg_write_enable)
            begin
                shadow_reg(cfg_index, cfg_data);
                busy = 1'b1;
            end
            if (in_valid && !in_stall)
            begin
                want = place_byte(pixel_byte);
                // directed rows with a typed answer are held to that instead
                if (row_typed)
                    want = row_exp;
                pending_writes.push_back(want);
                busy = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                busy = 1'b1;
                if (pending_writes.size() == 0)
                    flag_mismatch($sformatf("write to %h with nothing pending", dest_address));
                else
                begin
                    want = pending_writes.pop_front();
                    if (dest_address !== want.addr)
                        flag_mismatch($sformatf("dest_address %h, want %h",
                                                dest_address, want.addr));
                    if (dest_data !== want.data)
                        flag_mismatch($sformatf("dest_data %h, want %h (addr %h)",
                                                dest_data, want.data, want.addr));
                    if (write_enable !== want.we)
                        flag_mismatch($sformatf("write_enable %b, want %b (addr %h)",
                                                write_enable, want.we, want.addr));
                    if (frame_last !== want.last)
                        flag_mismatch($sformatf("frame_last %b, want %b (addr %h)",
                                                frame_last, want.last, want.addr));
                end
            end
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stretches of different stall density, plus one long
    // hold-off on demand so the pipe backs up into the request side.
    // ------------------------------------------------------------------
    int seg_left  = 0;
    int seg_mode  = 0;
    int hold_left = 0;

    always @(negedge clk)
    begin
        if (hold_served != hold_asked)
        begin
            hold_served <= hold_asked;
            hold_left   <= LONG_HOLD;
            out_stall   <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            if (seg_left == 0)
            begin
                seg_mode <= $urandom_range(0, 2);
                seg_left <= $urandom_range(4, 40);
            end
            else
                seg_left <= seg_left - 1;
            case (seg_mode)
                0:       out_stall <= 1'b0;                        // free running
                1:       out_stall <= ($urandom_range(0, 3) == 0); // light back-pressure
                default: out_stall <= ($urandom_range(0, 3) != 0); // heavy back-pressure
            endcase
        end
    end

    // Watchdog: nothing moving for too long means a hang
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("watchdog: no traffic for %0d cycles", QUIET_LIMIT);
        $display("FAIL yuv420_overlay_address_gen_core");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request side helpers (driven on the falling edge)
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [PIXEL_W-1:0] p, input bit typed,
                             input bg_write_t want);
        @(negedge clk);
        in_valid   <= 1'b1;
        pixel_byte <= p;
        row_typed   = typed;
        row_exp     = want;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic idle_gap(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= v;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
    endtask

    // Stop offering and wait for every predicted write, plus the pipe depth
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Random register values, mostly sane, now and then at the corners
    // ------------------------------------------------------------------
    function automatic logic [DIM_W-1:0] pick_bg_dim();
        case ($urandom_range(0, 9))
            0:
                case ($urandom_range(0, 3))
                    0:       return 13'd0;
                    1:       return 13'd1;
                    2:       return 13'd4096;
                    default: return 13'd8191;
                endcase
            1:       return 13'(2 * $urandom_range(1, 2047) + 1);    // odd width
            default: return 13'(2 * $urandom_range(1, 2048));
        endcase
    endfunction

    // overlay mostly small so frames complete inside a phase
    function automatic logic [DIM_W-1:0] pick_ov_dim();
        case ($urandom_range(0, 9))
            0:
                case ($urandom_range(0, 2))
                    0:       return 13'd0;
                    1:       return 13'd1;
                    default: return 13'd3;
                endcase
            1:       return 13'(2 * $urandom_range(1, 7) + 1);
            default: return 13'(2 * $urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [OFF_W-1:0] pick_offset(input logic [DIM_W-1:0] bg);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            // straddle the right or bottom border of the background
            2:       return (bg > 8) ? OFF_W'(bg - $urandom_range(1, 8)) : '0;
            3:       return OFF_W'($urandom_range(0, 4095));
            default: return OFF_W'($urandom_range(0, 32));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed plan
    // ------------------------------------------------------------------
    plan_row_t plan[$];

    function automatic void plan_reg(input logic [CFG_IDX_W-1:0] idx, input int v);
        plan_row_t r;
        r        = '{default: '0};
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.val    = CFG_W'(v);
        plan.push_back(r);
    endfunction

    function automatic void plan_byte(input logic [PIXEL_W-1:0] p, input bit typed = 1'b0,
                                      input int a = 0, input bit we = 1'b0,
                                      input bit last = 1'b0);
        plan_row_t r;
        r        = '{default: '0};
        r.pix    = p;
        r.typed  = typed;
        r.t_addr = ADDR_W'(a);
        r.t_we   = we;
        r.t_last = last;
        plan.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        bg_write_t        want;
        bit               prev_reg;
        bit               rushed;
        int               burst_left;
        logic [DIM_W-1:0] bgw, bgh, ovw, ovh;
        logic [OFF_W-1:0] ox, oy;

        // Out of reset at 1920x1080 with the overlay at the origin:
        // first two luma bytes go to addresses 0 and 1.
        plan_byte(8'h00, 1'b1, 0, 1'b1, 1'b0);
        plan_byte(8'hFF, 1'b1, 1, 1'b1, 1'b0);

        // Shrink everything to 2x2 while the scan sits at column 2:
        // that byte is outside the background and the column wraps after it,
        // then the rest of the frame runs to its last V byte.
        plan_reg(CFG_BG_WIDTH, 2);
        plan_reg(CFG_BG_HEIGHT, 2);
        plan_reg(CFG_OV_WIDTH, 2);
        plan_reg(CFG_OV_HEIGHT, 2);
        plan_reg(CFG_OFF_X, 0);
        plan_reg(CFG_OFF_Y, 0);
        plan_byte(8'h5A);
        plan_byte(8'hA5);
        plan_byte(8'h01);
        plan_byte(8'h80);
        plan_byte(8'h7F);

        // Huge background and far offsets: chroma addresses wrap the address space
        plan_reg(CFG_BG_WIDTH, 8191);
        plan_reg(CFG_BG_HEIGHT, 8191);
        plan_reg(CFG_OFF_X, 4095);
        plan_reg(CFG_OFF_Y, 4095);
        repeat (6) plan_byte(8'($urandom_range(0, 255)));

        // Odd overlay width and zero height: chroma planes collapse to 1x1
        plan_reg(CFG_BG_WIDTH, 4096);
        plan_reg(CFG_BG_HEIGHT, 4096);
        plan_reg(CFG_OV_WIDTH, 3);
        plan_reg(CFG_OV_HEIGHT, 0);
        plan_reg(CFG_OFF_X, 1);
        plan_reg(CFG_OFF_Y, 1);
        repeat (5) plan_byte(8'($urandom_range(0, 255)));

        // Overlay larger than the counters can span: sizes saturate
        plan_reg(CFG_OV_WIDTH, 8191);
        plan_reg(CFG_OV_HEIGHT, 8191);
        plan_reg(CFG_OFF_X, 0);
        plan_reg(CFG_OFF_Y, 4095);
        repeat (3) plan_byte(8'($urandom_range(0, 255)));

        // Reset is held from time zero and released on a falling edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        prev_reg = 1'b0;
        foreach (plan[i])
        begin
            if (plan[i].is_reg)
            begin
                // registers only change with the block drained
                if (!prev_reg)
                    settle();
                write_reg(plan[i].idx, plan[i].val);
            end
            else
            begin
                want = '{addr: plan[i].t_addr, data: plan[i].pix,
                         we: plan[i].t_we, last: plan[i].t_last};
                send_byte(plan[i].pix, plan[i].typed, want);
            end
            prev_reg = plan[i].is_reg;
        end
        settle();

        // Random phases: new geometry each time, scan carries on mid-frame.
        // Phase 0 is a 2x2 background and overlay at offset 0, phase 1 every register at its top,
        // phase 2 runs back to back into a long receiver hold-off.
        burst_left = 0;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph == 0)
            begin
                bgw = 13'd2;
                bgh = 13'd2;
                ovw = 13'd2;
                ovh = 13'd2;
                ox  = '0;
                oy  = '0;
            end
            else if (ph == 1)
            begin
                bgw = '1;
                bgh = '1;
                ovw = '1;
                ovh = '1;
                ox  = '1;
                oy  = '1;
            end
            else
            begin
                bgw = pick_bg_dim();
                bgh = pick_bg_dim();
                ovw = pick_ov_dim();
                ovh = pick_ov_dim();
                ox  = pick_offset(bgw);
                oy  = pick_offset(bgh);
            end
            write_reg(CFG_BG_WIDTH, bgw);
            write_reg(CFG_BG_HEIGHT, bgh);
            write_reg(CFG_OV_WIDTH, ovw);
            write_reg(CFG_OV_HEIGHT, ovh);
            write_reg(CFG_OFF_X, CFG_W'(ox));
            write_reg(CFG_OFF_Y, CFG_W'(oy));

            rushed = (ph == 2);
            if (rushed)
                hold_asked++;

            for (int k = 0; k < REQS_PER_PHASE; k++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 32);
                    if (!rushed && $urandom_range(0, 3) != 0)
                        idle_gap($urandom_range(1, 8));
                end
                burst_left--;
                send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            end
            settle();
        end

        // settle() already waited out the pipe; whatever is left is lost
        repeat (8) @(posedge clk);
        if (pending_writes.size() != 0)
            flag_mismatch($sformatf("%0d predicted writes never came out",
                                    pending_writes.size()));

        if (mismatches == 0)
            $display("PASS yuv420_overlay_address_gen_core");
        else
            $display("FAIL yuv420_overlay_address_gen_core");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/yoag_pkg.sv
rtl/core/yoag_addr.sv
rtl/core/yuv420_overlay_address_gen_core.sv
sim/yuv420_overlay_address_gen_core_tb.sv
